>>> rtl/trps_pkg.sv
// Shared types, widths and the arctangent table for the pursuit steering block.
package trps_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_DEPTH        = 24;
	localparam int ANG_W             = 32;
	localparam int VEC_W             = 36;
	localparam int ROT_W             = 28;
	localparam int ROT_ZW            = ANG_W + 1;
	localparam int GAIN_W            = 18;
	localparam int MAX_TURN_W        = 15;

	localparam logic [MAX_TURN_W-1:0] MAX_TURN_RESET = 15'd522;
	localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic signed [ROT_ZW-1:0] QUARTER_TURN = 33'sh0_4000_0000;
	// Reciprocal of the CORDIC gain, scaled by 2^16.
	localparam logic signed [GAIN_W-1:0] INV_GAIN = 18'sd39797;

	typedef struct packed {
		logic              target_active;
		logic signed [23:0] own_x;
		logic signed [23:0] own_y;
		logic signed [23:0] aim_x;
		logic signed [23:0] aim_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
	} item_t;

	typedef struct packed {
		logic signed [15:0] new_vel_x;
		logic signed [15:0] new_vel_y;
		logic signed [15:0] turn_applied;
	} result_t;

	// atan(2^-i), where 2^32 is one full turn.
	function automatic logic [ANG_W-1:0] atan_at(input int idx);
		logic [ANG_W-1:0] v;
		unique case (idx)
			0:       v = 32'h2000_0000;
			1:       v = 32'h12E4_051E;
			2:       v = 32'h09FB_385B;
			3:       v = 32'h0511_11D4;
			4:       v = 32'h028B_0D43;
			5:       v = 32'h0145_D7E1;
			6:       v = 32'h00A2_F61E;
			7:       v = 32'h0051_7C55;
			8:       v = 32'h0028_BE53;
			9:       v = 32'h0014_5F2F;
			10:      v = 32'h000A_2F98;
			11:      v = 32'h0005_17CC;
			12:      v = 32'h0002_8BE6;
			13:      v = 32'h0001_45F3;
			14:      v = 32'h0000_A2F9;
			15:      v = 32'h0000_517D;
			16:      v = 32'h0000_28BE;
			17:      v = 32'h0000_145F;
			18:      v = 32'h0000_0A30;
			19:      v = 32'h0000_0518;
			20:      v = 32'h0000_028C;
			21:      v = 32'h0000_0146;
			22:      v = 32'h0000_00A3;
			23:      v = 32'h0000_0051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/trps_vec_cell.sv
// One vectoring CORDIC cell: drives y towards zero and accumulates the angle.
module trps_vec_cell #(
	parameter int W     = trps_pkg::VEC_W,
	parameter int STAGE = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [W-1:0]           x_in,
	input  logic signed [W-1:0]           y_in,
	input  logic [trps_pkg::ANG_W-1:0]    z_in,
	output logic signed [W-1:0]           x_out,
	output logic signed [W-1:0]           y_out,
	output logic [trps_pkg::ANG_W-1:0]    z_out
);
	import trps_pkg::*;

	localparam logic [ANG_W-1:0] ATAN = atan_at(STAGE);

	logic signed [W-1:0] xs, ys;
	logic signed [W-1:0] x_q, y_q;
	logic [ANG_W-1:0]    z_q;

	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[W-1]) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

>>> rtl/trps_rot_cell.sv
// One rotating CORDIC cell: turns the vector by the residual angle's sign.
module trps_rot_cell #(
	parameter int W     = trps_pkg::ROT_W,
	parameter int STAGE = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [W-1:0]               x_in,
	input  logic signed [W-1:0]               y_in,
	input  logic signed [trps_pkg::ROT_ZW-1:0] z_in,
	output logic signed [W-1:0]               x_out,
	output logic signed [W-1:0]               y_out,
	output logic signed [trps_pkg::ROT_ZW-1:0] z_out
);
	import trps_pkg::*;

	localparam logic signed [ROT_ZW-1:0] ATAN = signed'(ROT_ZW'(atan_at(STAGE)));

	logic signed [W-1:0]      xs, ys;
	logic signed [W-1:0]      x_q, y_q;
	logic signed [ROT_ZW-1:0] z_q;

	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[ROT_ZW-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

>>> rtl/turn_rate_limited_pursuit_steer.sv
// Pursuit steering with a turn-rate limit: two vectoring chains, a clamp and a rotating chain.
//
// Usage: input words arrive on item/item_valid and are taken at an edge where
// item_valid is high and item_stall is low. Results leave on result/result_valid;
// the receiver holds result_stall high to keep a word in place. The max_turn
// register is written through cfg_data/cfg_valid, which is always ready.
// Each word passes one input register, NS = min(CORDIC_STAGES, ATAN_DEPTH) vectoring cells
// (bearing and heading side by side), a clamp register, NS rotating cells, a gain
// multiplier register and the result register on its way to result_valid.
// A new word is accepted in every cycle unless the pipeline stalls; the row of cells
// is fully pipelined.
// While the result register holds a word that the receiver stalls, the whole
// pipeline holds and item_stall is raised; otherwise words flow one per cycle.
// Reset clears all valid flags, so no result is presented, and loads max_turn
// with 522 binary angle units (about 0.05 rad).
// With no live target the velocity passes through unchanged and turn_applied
// is zero.
module turn_rate_limited_pursuit_steer #(
	parameter int CORDIC_STAGES = trps_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  trps_pkg::item_t                  item,
	input  logic                             item_valid,
	output logic                             item_stall,
	output trps_pkg::result_t                result,
	output logic                             result_valid,
	input  logic                             result_stall,
	input  logic [trps_pkg::MAX_TURN_W-1:0]  cfg_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready
);
	import trps_pkg::*;

	localparam int NS     = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
	localparam int PROD_W = ROT_W + GAIN_W;

	typedef struct packed {
		logic               active;
		logic               zero_b;
		logic               zero_h;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
	} vside_t;

	typedef struct packed {
		logic               active;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] turn;
	} rside_t;

	logic en;
	logic [MAX_TURN_W-1:0] max_turn_q;

	// Input stage.
	logic               vld_s1;
	logic               act_s1;
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [15:0] vx_s1, vy_s1;

	// Vectoring row.
	logic signed [VEC_W-1:0] bx_in, by_in, bx_ext, by_ext;
	logic signed [VEC_W-1:0] hx_in, hy_in, hx_ext, hy_ext;
	logic [ANG_W-1:0]        bz_in, hz_in;
	logic signed [VEC_W-1:0] bx [0:NS-1];
	logic signed [VEC_W-1:0] by [0:NS-1];
	logic [ANG_W-1:0]        bz [0:NS-1];
	logic signed [VEC_W-1:0] hx [0:NS-1];
	logic signed [VEC_W-1:0] hy [0:NS-1];
	logic [ANG_W-1:0]        hz [0:NS-1];
	vside_t                  vside_in;
	vside_t                  vside_q [0:NS-1];
	logic [NS-1:0]           vld_v_q;

	// Clamp stage.
	vside_t             vs_end;
	logic [15:0]        tgt, hdg;
	logic signed [15:0] diff, lim, turn_c;
	logic               vld_s2, act_s2;
	logic signed [15:0] vx_s2, vy_s2, turn_s2;

	// Rotating row.
	logic signed [ROT_W-1:0]  rx_ext, ry_ext, rx_in, ry_in;
	logic signed [ROT_ZW-1:0] rz_ext, rz_in;
	logic signed [ROT_W-1:0]  rx [0:NS-1];
	logic signed [ROT_W-1:0]  ry [0:NS-1];
	logic signed [ROT_ZW-1:0] rz [0:NS-1];
	rside_t                   rside_in;
	rside_t                   rside_q [0:NS-1];
	logic [NS-1:0]            vld_r_q;

	// Gain and output stages.
	logic                      vld_s3;
	rside_t                    rside_s3;
	logic signed [PROD_W-1:0]  px_s3, py_s3;
	result_t                   res_q;
	logic                      res_valid_q;

	// Stall only when the result register holds a word the receiver is not taking.
	assign en         = !(res_valid_q && result_stall);
	assign item_stall = !en;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_turn_q <= MAX_TURN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_turn_q <= cfg_data;
		end
	end

	// Valid flags of the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_v_q     <= '0;
			vld_s2      <= 1'b0;
			vld_r_q     <= '0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= item_valid;
			vld_v_q     <= NS'({vld_v_q, vld_s1});
			vld_s2      <= vld_v_q[NS-1];
			vld_r_q     <= NS'({vld_r_q, vld_s2});
			vld_s3      <= vld_r_q[NS-1];
			res_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= item.target_active;
			dx_s1  <= 25'(item.aim_x) - 25'(item.own_x);
			dy_s1  <= 25'(item.aim_y) - 25'(item.own_y);
			vx_s1  <= item.vel_x;
			vy_s1  <= item.vel_y;
		end
	end

	// Scale by 2^8 and fold the left half-plane onto the right one.
	always_comb begin
		bx_ext = VEC_W'(dx_s1) <<< 8;
		by_ext = VEC_W'(dy_s1) <<< 8;
		hx_ext = VEC_W'(vx_s1) <<< 8;
		hy_ext = VEC_W'(vy_s1) <<< 8;
		bx_in  = bx_ext[VEC_W-1] ? -bx_ext : bx_ext;
		by_in  = bx_ext[VEC_W-1] ? -by_ext : by_ext;
		bz_in  = bx_ext[VEC_W-1] ? HALF_TURN : '0;
		hx_in  = hx_ext[VEC_W-1] ? -hx_ext : hx_ext;
		hy_in  = hx_ext[VEC_W-1] ? -hy_ext : hy_ext;
		hz_in  = hx_ext[VEC_W-1] ? HALF_TURN : '0;
		vside_in.active = act_s1;
		vside_in.zero_b = (dx_s1 == '0) && (dy_s1 == '0);
		vside_in.zero_h = (vx_s1 == '0) && (vy_s1 == '0);
		vside_in.vel_x  = vx_s1;
		vside_in.vel_y  = vy_s1;
	end

	for (genvar k = 0; k < NS; k++) begin : g_vec
		if (k == 0) begin : g_first
			trps_vec_cell #(.W(VEC_W), .STAGE(k)) u_bear (
				.clk(clk), .en(en),
				.x_in(bx_in), .y_in(by_in), .z_in(bz_in),
				.x_out(bx[k]), .y_out(by[k]), .z_out(bz[k])
			);
			trps_vec_cell #(.W(VEC_W), .STAGE(k)) u_head (
				.clk(clk), .en(en),
				.x_in(hx_in), .y_in(hy_in), .z_in(hz_in),
				.x_out(hx[k]), .y_out(hy[k]), .z_out(hz[k])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					vside_q[k] <= vside_in;
				end
			end
		end else begin : g_next
			trps_vec_cell #(.W(VEC_W), .STAGE(k)) u_bear (
				.clk(clk), .en(en),
				.x_in(bx[k-1]), .y_in(by[k-1]), .z_in(bz[k-1]),
				.x_out(bx[k]), .y_out(by[k]), .z_out(bz[k])
			);
			trps_vec_cell #(.W(VEC_W), .STAGE(k)) u_head (
				.clk(clk), .en(en),
				.x_in(hx[k-1]), .y_in(hy[k-1]), .z_in(hz[k-1]),
				.x_out(hx[k]), .y_out(hy[k]), .z_out(hz[k])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					vside_q[k] <= vside_q[k-1];
				end
			end
		end
	end

	// Round both angles to 16 bits, take the wrapped difference and clamp it.
	always_comb begin
		vs_end = vside_q[NS-1];
		tgt    = vs_end.zero_b ? 16'h0000 : bz[NS-1][31:16] + {15'b0, bz[NS-1][15]};
		hdg    = vs_end.zero_h ? 16'h0000 : hz[NS-1][31:16] + {15'b0, hz[NS-1][15]};
		diff   = signed'(tgt - hdg);
		lim    = signed'({1'b0, max_turn_q});
		if (diff > lim) begin
			turn_c = lim;
		end else if (diff < -lim) begin
			turn_c = -lim;
		end else begin
			turn_c = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2  <= vs_end.active;
			vx_s2   <= vs_end.vel_x;
			vy_s2   <= vs_end.vel_y;
			turn_s2 <= turn_c;
		end
	end

	// Exact quarter-turn swap brings the angle within reach of the cells.
	always_comb begin
		rx_ext = ROT_W'(vx_s2) <<< 8;
		ry_ext = ROT_W'(vy_s2) <<< 8;
		rz_ext = ROT_ZW'(turn_s2) <<< 16;
		if (rz_ext > QUARTER_TURN) begin
			rx_in = -ry_ext;
			ry_in = rx_ext;
			rz_in = rz_ext - QUARTER_TURN;
		end else if (rz_ext < -QUARTER_TURN) begin
			rx_in = ry_ext;
			ry_in = -rx_ext;
			rz_in = rz_ext + QUARTER_TURN;
		end else begin
			rx_in = rx_ext;
			ry_in = ry_ext;
			rz_in = rz_ext;
		end
		rside_in.active = act_s2;
		rside_in.vel_x  = vx_s2;
		rside_in.vel_y  = vy_s2;
		rside_in.turn   = turn_s2;
	end

	for (genvar k = 0; k < NS; k++) begin : g_rot
		if (k == 0) begin : g_first
			trps_rot_cell #(.W(ROT_W), .STAGE(k)) u_cell (
				.clk(clk), .en(en),
				.x_in(rx_in), .y_in(ry_in), .z_in(rz_in),
				.x_out(rx[k]), .y_out(ry[k]), .z_out(rz[k])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					rside_q[k] <= rside_in;
				end
			end
		end else begin : g_next
			trps_rot_cell #(.W(ROT_W), .STAGE(k)) u_cell (
				.clk(clk), .en(en),
				.x_in(rx[k-1]), .y_in(ry[k-1]), .z_in(rz[k-1]),
				.x_out(rx[k]), .y_out(ry[k]), .z_out(rz[k])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					rside_q[k] <= rside_q[k-1];
				end
			end
		end
	end

	// The residual angle of the last cell is not needed.
	logic rz_unused;
	assign rz_unused = ^rz[NS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			rside_s3 <= rside_q[NS-1];
			px_s3    <= PROD_W'(rx[NS-1]) * PROD_W'(INV_GAIN);
			py_s3    <= PROD_W'(ry[NS-1]) * PROD_W'(INV_GAIN);
		end
	end

	// Round half up at 2^-24 and saturate to 16 bits.
	function automatic logic signed [15:0] finish(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		logic signed [PROD_W-25:0] r;
		s = p + (PROD_W'(1) <<< 23);
		r = (PROD_W-24)'(s >>> 24);
		if (r > (PROD_W-24)'(32767)) begin
			return 16'sh7FFF;
		end else if (r < -(PROD_W-24)'(32768)) begin
			return 16'sh8000;
		end
		return 16'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			if (rside_s3.active) begin
				res_q.new_vel_x    <= finish(px_s3);
				res_q.new_vel_y    <= finish(py_s3);
				res_q.turn_applied <= rside_s3.turn;
			end else begin
				res_q.new_vel_x    <= rside_s3.vel_x;
				res_q.new_vel_y    <= rside_s3.vel_y;
				res_q.turn_applied <= '0;
			end
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule
